>>> design/hsv2rgb_pkg.sv
// types and constants for the hsv to rgb pixel converter
// depends on nothing; imported by hsv_to_rgb_converter
package hsv2rgb_pkg;

	// one input pixel
	typedef struct packed {
		logic [15:0] hue_frac;
		logic [8:0]  sat_level;
		logic [8:0]  val_level;
	} hsv_pixel_t;

	// one output pixel
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_pixel_t;

	// fixed point unity for saturation and value
	localparam logic [8:0]  ONE_LEVEL = 9'd256;
	// unity of the hue fraction f
	localparam logic [16:0] FRAC_ONE  = 17'h1_0000;
	// unity of a channel multiplier (over 2^24)
	localparam logic [24:0] ONE_MULT  = 25'h100_0000;
	// unity of a channel numerator (over 2^32)
	localparam logic [32:0] ONE_NUM   = 33'h1_0000_0000;
	// largest channel code
	localparam logic [7:0]  CHAN_MAX  = 8'd255;

	// hue sectors
	localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
	localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
	localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
	localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
	localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
	localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

endpackage

>>> design/hsv_to_rgb_converter.sv
// hsv to rgb pixel converter, four stage pipeline
// depends on hsv2rgb_pkg for the pixel types and constants
//
//  channel | signals                   | direction | payload
//  --------+---------------------------+-----------+--------------------------
//  hsv     | hsv_valid, hsv_ready, hsv | in        | hue_frac, sat_level, val_level
//  rgb     | rgb_valid, rgb_ready, rgb | out       | red_out, green_out, blue_out
//
// one pixel a cycle while the pipeline is not held; an accepted pixel passes the stage 1 to 4 registers to rgb_valid
// stages: sector split and clamp, f*s products, select and v multiply, x255 and clamp
// the whole pipeline holds when the output register is full and rgb_ready is low
// reset clears the stage valid bits only; the datapath registers are not reset
module hsv_to_rgb_converter (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    hsv_valid,
	output logic                    hsv_ready,
	input  hsv2rgb_pkg::hsv_pixel_t hsv,
	output logic                    rgb_valid,
	input  logic                    rgb_ready,
	output hsv2rgb_pkg::rgb_pixel_t rgb
);
	import hsv2rgb_pkg::*;

	// pipeline advance
	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign en        = !valid_s4 || rgb_ready;
	assign hsv_ready = en;

	// stage 1: clamp, hue times six
	logic [18:0] h6;
	logic [8:0]  sat_c, val_c;
	logic [2:0]  sector_s1;
	logic [15:0] f_s1;
	logic [8:0]  sat_s1, val_s1;

	assign h6    = {1'b0, hsv.hue_frac, 2'b00} + {2'b00, hsv.hue_frac, 1'b0};
	assign sat_c = (hsv.sat_level > ONE_LEVEL) ? ONE_LEVEL : hsv.sat_level;
	assign val_c = (hsv.val_level > ONE_LEVEL) ? ONE_LEVEL : hsv.val_level;

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= h6[18:16];
			f_s1      <= h6[15:0];
			sat_s1    <= sat_c;
			val_s1    <= val_c;
		end
	end

	// stage 2: multipliers for p, q and t over 2^24
	logic [24:0] fs;
	logic [25:0] gs;
	logic [16:0] f_inv;
	logic [8:0]  sat_inv;
	logic [24:0] m_p_s2, m_q_s2, m_t_s2;
	logic [2:0]  sector_s2;
	logic [8:0]  val_s2;

	assign f_inv   = FRAC_ONE - {1'b0, f_s1};
	assign fs      = f_s1 * sat_s1;
	assign gs      = f_inv * sat_s1;
	assign sat_inv = ONE_LEVEL - sat_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			m_p_s2    <= {sat_inv, 16'h0000};
			m_q_s2    <= ONE_MULT - fs;
			m_t_s2    <= ONE_MULT - gs[24:0];
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
		end
	end

	// stage 3: sector select and multiply by value
	logic [24:0] m_r, m_g, m_b;
	logic [33:0] prod_r, prod_g, prod_b;
	logic [32:0] num_r_s3, num_g_s3, num_b_s3;

	always_comb begin
		case (sector_s2)
			SECTOR_RED_YELLOW: begin
				m_r = ONE_MULT; m_g = m_t_s2;   m_b = m_p_s2;
			end
			SECTOR_YELLOW_GREEN: begin
				m_r = m_q_s2;   m_g = ONE_MULT; m_b = m_p_s2;
			end
			SECTOR_GREEN_CYAN: begin
				m_r = m_p_s2;   m_g = ONE_MULT; m_b = m_t_s2;
			end
			SECTOR_CYAN_BLUE: begin
				m_r = m_p_s2;   m_g = m_q_s2;   m_b = ONE_MULT;
			end
			SECTOR_BLUE_MAGENTA: begin
				m_r = m_t_s2;   m_g = m_p_s2;   m_b = ONE_MULT;
			end
			default: begin
				m_r = ONE_MULT; m_g = m_p_s2;   m_b = m_q_s2;
			end
		endcase
	end

	assign prod_r = val_s2 * m_r;
	assign prod_g = val_s2 * m_g;
	assign prod_b = val_s2 * m_b;

	always_ff @(posedge clk) begin
		if (en) begin
			num_r_s3 <= prod_r[32:0];
			num_g_s3 <= prod_g[32:0];
			num_b_s3 <= prod_b[32:0];
		end
	end

	// stage 4: floor(num * 255 / 2^32), clamped, into the output register
	logic [40:0] x_r, x_g, x_b;
	rgb_pixel_t  rgb_s4;

	assign x_r = {num_r_s3, 8'h00} - {8'h00, num_r_s3};
	assign x_g = {num_g_s3, 8'h00} - {8'h00, num_g_s3};
	assign x_b = {num_b_s3, 8'h00} - {8'h00, num_b_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s4.red_out   <= x_r[40] ? CHAN_MAX : x_r[39:32];
			rgb_s4.green_out <= x_g[40] ? CHAN_MAX : x_g[39:32];
			rgb_s4.blue_out  <= x_b[40] ? CHAN_MAX : x_b[39:32];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= hsv_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign rgb_valid = valid_s4;
	assign rgb       = rgb_s4;

	// checks
	a_stage1_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (sector_s1 <= SECTOR_MAGENTA_RED) && (sat_s1 <= ONE_LEVEL)
			&& (val_s1 <= ONE_LEVEL))
		else $error("stage 1 sector or clamp out of range");

	a_mult_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (m_q_s2 <= ONE_MULT) && (m_t_s2 <= ONE_MULT) && (m_p_s2 <= ONE_MULT))
		else $error("channel multiplier above unity");

	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (num_r_s3 <= ONE_NUM) && (num_g_s3 <= ONE_NUM)
			&& (num_b_s3 <= ONE_NUM))
		else $error("channel numerator above unity");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en) |=> valid_s3 && $stable(num_r_s3) && $stable(num_b_s3))
		else $error("stage 3 changed during a stall");

endmodule

>>> tb/tb_hsv_to_rgb_converter.sv
// testbench for hsv_to_rgb_converter: directed and random pixels, gaps on both handshakes
// depends on hsv2rgb_pkg for the pixel types and constants, and on the converter rtl
module tb_hsv_to_rgb_converter;
	import hsv2rgb_pkg::*;

	localparam int HOLD_OFF_CYCLES = 80;
	localparam int MAX_REPORTS     = 10;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       hsv_valid = 1'b0;
	logic       hsv_ready;
	hsv_pixel_t hsv       = '0;
	logic       rgb_valid;
	logic       rgb_ready = 1'b0;
	rgb_pixel_t rgb;

	// expected colours, oldest first
	rgb_pixel_t rgb_expected_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pixels_sent    = 0;
	int pixels_checked = 0;
	int fault_count    = 0;
	int stall_cycles   = 0;

	// output hold-off request, toggled by the test and counted out by the receiver
	logic rx_hold_req  = 1'b0;
	logic rx_hold_seen = 1'b0;
	int   rx_hold_left = 0;

	hsv_to_rgb_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsv_valid(hsv_valid),
		.hsv_ready(hsv_ready),
		.hsv      (hsv),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.rgb      (rgb)
	);

	// clock, period 12
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// channel code from a numerator over 2^32: floor(x*255), clamped
	function automatic logic [7:0] scale_channel(input logic [63:0] num);
		logic [63:0] code;
		code = (num * 64'd255) >> 32;
		return (code > 64'd255) ? CHAN_MAX : code[7:0];
	endfunction

	// six-sector hexcone conversion, exact over the common denominator 2^32
	function automatic rgb_pixel_t predict_rgb(input hsv_pixel_t px);
		logic [63:0] s, v, h6, f, vn, pn, qn, tn, rn, gn, bn;
		logic [2:0]  sector;
		rgb_pixel_t  colour;
		s = (px.sat_level > ONE_LEVEL) ? 64'(ONE_LEVEL) : 64'(px.sat_level);
		v = (px.val_level > ONE_LEVEL) ? 64'(ONE_LEVEL) : 64'(px.val_level);
		h6 = 64'(px.hue_frac) * 64'd6;
		sector = h6[18:16];
		f = 64'(h6[15:0]);
		vn = v << 24;
		pn = (v * (64'(ONE_LEVEL) - s)) << 16;
		qn = v * (64'(ONE_MULT) - f * s);
		tn = v * (64'(ONE_MULT) - (64'(FRAC_ONE) - f) * s);
		case (sector)
			SECTOR_RED_YELLOW: begin
				rn = vn; gn = tn; bn = pn;
			end
			SECTOR_YELLOW_GREEN: begin
				rn = qn; gn = vn; bn = pn;
			end
			SECTOR_GREEN_CYAN: begin
				rn = pn; gn = vn; bn = tn;
			end
			SECTOR_CYAN_BLUE: begin
				rn = pn; gn = qn; bn = vn;
			end
			SECTOR_BLUE_MAGENTA: begin
				rn = tn; gn = pn; bn = vn;
			end
			default: begin
				rn = vn; gn = pn; bn = qn;
			end
		endcase
		colour.red_out   = scale_channel(rn);
		colour.green_out = scale_channel(gn);
		colour.blue_out  = scale_channel(bn);
		return colour;
	endfunction

	// receiver: random ready, or a long hold-off when requested
	always @(posedge clk) begin
		if (!arst_n) begin
			rgb_ready    <= 1'b0;
			rx_hold_seen <= rx_hold_req;
			rx_hold_left <= 0;
		end else if (rx_hold_req != rx_hold_seen) begin
			rx_hold_seen <= rx_hold_req;
			rx_hold_left <= HOLD_OFF_CYCLES - 1;
			rgb_ready    <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			rgb_ready    <= 1'b0;
		end else begin
			rgb_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// count cycles in which the block refuses an offered pixel
	always @(posedge clk) begin
		if (arst_n && hsv_valid && !hsv_ready)
			stall_cycles <= stall_cycles + 1;
	end

	// check each output transaction against the oldest expected colour
	always @(posedge clk) begin
		rgb_pixel_t want;
		if (arst_n && rgb_valid && rgb_ready) begin
			if (rgb_expected_q.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("unexpected rgb transaction: r=%0d g=%0d b=%0d",
						rgb.red_out, rgb.green_out, rgb.blue_out);
			end else begin
				want = rgb_expected_q.pop_front();
				pixels_checked++;
				if (rgb.red_out !== want.red_out || rgb.green_out !== want.green_out ||
						rgb.blue_out !== want.blue_out) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("mismatch #%0d: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							pixels_checked, want.red_out, want.green_out, want.blue_out,
							rgb.red_out, rgb.green_out, rgb.blue_out);
				end
			end
		end
	end

	// offer one pixel, with a random gap first, and hold it until accepted
	task automatic send_pixel(input hsv_pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			hsv_valid <= 1'b0;
			@(posedge clk);
		end
		hsv       <= px;
		hsv_valid <= 1'b1;
		do @(posedge clk); while (!hsv_ready);
		rgb_expected_q.push_back(predict_rgb(px));
		pixels_sent++;
	endtask

	task automatic send_hsv(input int hue, input int sat, input int val);
		hsv_pixel_t px;
		px.hue_frac  = hue[15:0];
		px.sat_level = sat[8:0];
		px.val_level = val[8:0];
		send_pixel(px);
	endtask

	// stop offering and wait until every expected colour has come out
	task automatic wait_for_colours();
		hsv_valid <= 1'b0;
		while (rgb_expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// saturation or value: mostly in range, with zero, unity and clamped values
	function automatic logic [8:0] rand_level();
		case ($urandom_range(9))
			0:       return 9'd0;
			1:       return ONE_LEVEL;
			2, 3:    return 9'($urandom_range(511, 257));
			default: return 9'($urandom_range(256));
		endcase
	endfunction

	// hue: mostly uniform, sometimes near a sector boundary
	function automatic logic [15:0] rand_hue();
		int edge_hue;
		if ($urandom_range(3) == 0) begin
			edge_hue = ($urandom_range(6) * 65536 + 5) / 6 + $urandom_range(6) - 3;
			return edge_hue[15:0];
		end
		return 16'($urandom_range(65535));
	endfunction

	task automatic send_random_pixels(input int count);
		hsv_pixel_t px;
		repeat (count) begin
			px.hue_frac  = rand_hue();
			px.sat_level = rand_level();
			px.val_level = rand_level();
			send_pixel(px);
		end
	endtask

	// extremes of every field, each sector, sector edges and clamping
	task automatic test_directed_pixels();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_hsv(0, 256, 256);
		send_hsv(65535, 256, 256);
		send_hsv(0, 0, 0);
		send_hsv(0, 0, 256);
		send_hsv(12345, 0, 128);
		send_hsv(20000, 511, 511);
		send_hsv(40000, 257, 257);
		send_hsv(30000, 511, 100);
		send_hsv(50000, 100, 511);
		for (int k = 0; k < 6; k++)
			send_hsv(k * 10923 + 5461, 200, 200);
		send_hsv(10922, 256, 200);
		send_hsv(10923, 256, 200);
		send_hsv(54613, 256, 200);
		send_hsv(54614, 256, 200);
		send_hsv(16'h5555, 255, 255);
		send_hsv(16'hAAAA, 1, 1);
		send_hsv(16'hFFFF, 0, 511);
		wait_for_colours();
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct = 31;
		recv_idle_pct = 80;
		send_random_pixels(400);
		wait_for_colours();
	endtask

	task automatic test_random_receiver_gaps();
		send_idle_pct = 80;
		recv_idle_pct = 31;
		send_random_pixels(400);
		wait_for_colours();
	endtask

	// receiver stops for a long stretch while pixels keep coming, so the pipeline fills
	task automatic test_output_hold_off();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rx_hold_req <= ~rx_hold_req;
		send_random_pixels(60);
		wait_for_colours();
	endtask

	task automatic test_full_rate_stream();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_pixels(380);
		wait_for_colours();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_pixels();
		test_random_sender_gaps();
		test_random_receiver_gaps();
		test_output_hold_off();
		test_full_rate_stream();
		$display("%0d pixels checked: field extremes, all six sectors and their edges, clamping,",
			pixels_checked);
		$display("random gaps on both sides, full rate, and an output hold-off (%0d stalled cycles)",
			stall_cycles);
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// overall limit on the run
	initial begin
		#(12 * 400000);
		$display("timeout with %0d colours outstanding", rgb_expected_q.size());
		$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
design/hsv2rgb_pkg.sv
design/hsv_to_rgb_converter.sv
tb/tb_hsv_to_rgb_converter.sv
